// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks in the transform RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same clock edge, disabled while reset is high.
`define HBT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hbt91 check failed");

// Antecedent on one edge, consequent on the following edge.
`define HBT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbt91 check failed");

`endif

// ===== hw/rtl/hbt91_pkg.sv =====
// ----------------------------------------------------------------------------
// hbt91_pkg
// Types, constants and arithmetic helpers for the mod-91 block transform.
// ----------------------------------------------------------------------------
package hbt91_pkg;

   localparam int ALPHA     = 91;
   localparam int BASE_CHAR = 32;
   localparam int SYM_W     = 7;
   localparam int BYTE_W    = 7;
   localparam int KEY_W     = 56;
   localparam int ROW_KEY_W = 28;
   localparam int BS_W      = 3;
   localparam int ROW_W     = 2;
   localparam int COL_W     = 2;
   localparam int PROD_W    = 13;
   localparam int CSR_IDX_W = 2;

   // Reciprocal of the alphabet size, 2^17 / 91 rounded down.
   localparam int RECIP_MUL   = 1440;
   localparam int RECIP_SHIFT = 17;
   localparam int RECIP_W     = 11;

   localparam logic [BS_W-1:0]  BS_RESET        = 3'd1;
   localparam logic [KEY_W-1:0] KEY_UPPER_RESET = 56'd34359738369;
   localparam logic [KEY_W-1:0] KEY_LOWER_RESET = 56'd562949953437696;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_SIZE = 2'd0,
      CSR_KEY_UPPER  = 2'd1,
      CSR_KEY_LOWER  = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [KEY_W-1:0] upper;
      logic [KEY_W-1:0] lower;
   } key_type;

   // One row of the dot product travelling along the cells.
   typedef struct packed {
      logic             vld;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [SYM_W-1:0] acc;
   } chain_type;

   // Map a character to its symbol, (byte - 32) mod 91.
   function automatic logic [SYM_W-1:0] to_symbol(input logic [BYTE_W-1:0] b);
      logic [BYTE_W:0] t;
      t = {1'b0, b} + 8'(ALPHA - BASE_CHAR);
      if (t >= 8'(2 * ALPHA)) begin
         t = t - 8'(2 * ALPHA);
      end else if (t >= 8'(ALPHA)) begin
         t = t - 8'(ALPHA);
      end
      return t[SYM_W-1:0];
   endfunction

   // Key entry (row, col), reduced mod 91.
   function automatic logic [SYM_W-1:0] key_entry(input key_type k,
                                                  input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
      logic [ROW_KEY_W-1:0] rw;
      logic [SYM_W-1:0]     e;
      case (row)
         2'd0:    rw = k.upper[ROW_KEY_W-1:0];
         2'd1:    rw = k.upper[KEY_W-1:ROW_KEY_W];
         2'd2:    rw = k.lower[ROW_KEY_W-1:0];
         default: rw = k.lower[KEY_W-1:ROW_KEY_W];
      endcase
      e = rw[int'(col) * SYM_W +: SYM_W];
      if (e >= 7'(ALPHA)) begin
         e = e - 7'(ALPHA);
      end
      return e;
   endfunction

   // x mod 91 for x below 8192: reciprocal estimate, then one correction.
   function automatic logic [SYM_W-1:0] mod_alpha(input logic [PROD_W-1:0] x);
      logic [PROD_W+RECIP_W-1:0] est;
      logic [SYM_W-1:0]          q;
      logic [PROD_W-1:0]         qa;
      logic [SYM_W:0]            r;
      est = {{RECIP_W{1'b0}}, x} * (PROD_W + RECIP_W)'(RECIP_MUL);
      q   = est[RECIP_SHIFT +: SYM_W];
      qa  = {{(PROD_W - SYM_W){1'b0}}, q} * PROD_W'(ALPHA);
      r   = 8'(x - qa);
      if (r >= 8'(ALPHA)) begin
         r = r - 8'(ALPHA);
      end
      return r[SYM_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/hbt91_cell.sv =====
// ----------------------------------------------------------------------------
// hbt91_cell
// One column of the dot-product chain: holds one symbol and adds its term.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbt91_cell #(
   parameter int COL = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic [hbt91_pkg::BS_W-1:0]        blk_n,
   input  hbt91_pkg::key_type                key,
   input  logic                              sym_we,
   input  logic [hbt91_pkg::SYM_W-1:0]       sym_wdata,
   input  hbt91_pkg::chain_type              chain_in,
   output hbt91_pkg::chain_type              chain_out
);

   logic [hbt91_pkg::SYM_W-1:0]  sym_ff;
   hbt91_pkg::chain_type         a_ff, a_in;
   hbt91_pkg::chain_type         b_ff, b_in;
   logic [hbt91_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [hbt91_pkg::SYM_W-1:0]  key_val;
   logic                         active;

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_ff <= sym_wdata;
      end
   end

   // Columns beyond the current block size contribute nothing.
   assign active  = (3'(COL) < blk_n);
   assign key_val = hbt91_pkg::key_entry(key, chain_in.row, 2'(COL));

   always_comb begin
      a_in    = chain_in;
      prod_in = '0;
      if (active) begin
         prod_in = {6'd0, key_val} * {6'd0, sym_ff};
      end
      b_in     = a_ff;
      b_in.acc = hbt91_pkg::mod_alpha({6'd0, a_ff.acc} + prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.vld <= 1'b0;
         b_ff.vld <= 1'b0;
      end else if (adv) begin
         a_ff    <= a_in;
         prod_ff <= prod_in;
         b_ff    <= b_in;
      end
   end

   assign chain_out = b_ff;

   `HBT_ASSERT(a_cell_acc_range, clock, reset, !b_ff.vld || (b_ff.acc < 7'(hbt91_pkg::ALPHA)))
   `HBT_ASSERT_NEXT(a_cell_hold, clock, reset, !adv, $stable(b_ff))
   `HBT_ASSERT_NEXT(a_cell_take, clock, reset, adv && chain_in.vld, a_ff.vld)

endmodule

// ===== hw/rtl/hill_block_transform_mod91_top.sv =====
// ----------------------------------------------------------------------------
// hill_block_transform_mod91_top
// Hill-cipher block decryption over a 91-symbol alphabet, systolic row chain.
// ----------------------------------------------------------------------------
// The first result of a block passes through the injection register, the
// a and b registers of each cell and the output register; results then
// follow one per cycle while rsp_stall is low. Input is stalled from
// block completion until its last result has been taken.
// Reset: synchronous, active high; clears the block size to 1 and the key to
// the identity. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hill_block_transform_mod91_top #(
   parameter int MAX_BLOCK = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // Ciphertext characters in.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [hbt91_pkg::BYTE_W-1:0]        req_cipher_byte,
   // Plaintext characters out.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [hbt91_pkg::BYTE_W-1:0]        rsp_plain_byte,
   output logic                                rsp_block_last,
   // Register writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hbt91_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hbt91_pkg::KEY_W-1:0]         csr_wdata
);

   localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

   // ------------------------------------------------------------------------
   // Configuration registers. Writes are always accepted; an index beyond
   // the register list is ignored.
   // ------------------------------------------------------------------------
   logic [hbt91_pkg::BS_W-1:0] bs_ff, bs_in;
   hbt91_pkg::key_type         key_ff, key_in;

   assign csr_ready = 1'b1;

   always_comb begin
      bs_in  = bs_ff;
      key_in = key_ff;
      if (csr_valid) begin
         case (hbt91_pkg::csr_idx_type'(csr_index))
            hbt91_pkg::CSR_BLOCK_SIZE: bs_in        = csr_wdata[hbt91_pkg::BS_W-1:0];
            hbt91_pkg::CSR_KEY_UPPER:  key_in.upper = csr_wdata;
            hbt91_pkg::CSR_KEY_LOWER:  key_in.lower = csr_wdata;
            default:                   bs_in        = bs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff        <= hbt91_pkg::BS_RESET;
         key_ff.upper <= hbt91_pkg::KEY_UPPER_RESET;
         key_ff.lower <= hbt91_pkg::KEY_LOWER_RESET;
      end else begin
         bs_ff  <= bs_in;
         key_ff <= key_in;
      end
   end

   // Effective block size: zero counts as one, and it saturates at the
   // number of cells.
   logic [hbt91_pkg::BS_W-1:0] blk_n;

   always_comb begin
      if (bs_ff == '0) begin
         blk_n = 3'd1;
      end else if (bs_ff > 3'(MAX_BLOCK)) begin
         blk_n = 3'(MAX_BLOCK);
      end else begin
         blk_n = bs_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Block control. Characters are written into the cell selected by the
   // fill count. When the block is complete, one row token per active key row is
   // injected into the head of the chain, and the input side stalls until
   // the final result of the block has been taken.
   // ------------------------------------------------------------------------
   logic                          busy_ff, busy_in;
   logic                          inj_ff, inj_in;
   logic [IDX_W-1:0]              fill_ff, fill_in;
   logic [hbt91_pkg::ROW_W-1:0]   row_ff, row_in;
   logic                          accept;
   logic                          blk_done;
   logic                          row_last;
   logic                          adv;
   logic                          rsp_done;
   logic [hbt91_pkg::SYM_W-1:0]   req_sym;

   // Output register state.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hbt91_pkg::BYTE_W-1:0]  rsp_plain_ff, rsp_plain_in;
   logic                          rsp_last_ff, rsp_last_in;

   hbt91_pkg::chain_type          chain [MAX_BLOCK+1];

   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign req_sym   = hbt91_pkg::to_symbol(req_cipher_byte);
   // When the block size has been lowered mid-block, the fill count may
   // already reach it; the next character then completes the block.
   assign blk_done  = ((3'(fill_ff) + 3'd1) >= blk_n);
   assign row_last  = ((3'(row_ff) + 3'd1) == blk_n);

   // The whole chain moves whenever the output register can take a word.
   assign adv      = !rsp_valid_ff || !rsp_stall;
   assign rsp_done = rsp_valid_ff && !rsp_stall && rsp_last_ff;

   always_comb begin
      busy_in = busy_ff;
      inj_in  = inj_ff;
      fill_in = fill_ff;
      row_in  = row_ff;
      if (accept) begin
         if (blk_done) begin
            fill_in = '0;
            busy_in = 1'b1;
            inj_in  = 1'b1;
            row_in  = '0;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (adv && inj_ff) begin
         if (row_last) begin
            inj_in = 1'b0;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
      if (rsp_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         inj_ff  <= 1'b0;
         fill_ff <= '0;
         row_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         inj_ff  <= inj_in;
         fill_ff <= fill_in;
         row_ff  <= row_in;
      end
   end

   // ------------------------------------------------------------------------
   // Cell chain. Each cell holds one symbol of the block and adds its term
   // key(row, col) * symbol(col) to the running residue of the row token.
   // ------------------------------------------------------------------------
   always_comb begin
      chain[0].vld  = inj_ff;
      chain[0].last = row_last;
      chain[0].row  = row_ff;
      chain[0].acc  = '0;
   end

   for (genvar c = 0; c < MAX_BLOCK; c++) begin : g_cell
      hbt91_cell #(
         .COL (c)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .blk_n     (blk_n),
         .key       (key_ff),
         .sym_we    (accept && (fill_ff == IDX_W'(c))),
         .sym_wdata (req_sym),
         .chain_in  (chain[c]),
         .chain_out (chain[c+1])
      );
   end

   // ------------------------------------------------------------------------
   // Output register: the residue is shifted back into the printable range.
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_plain_in = rsp_plain_ff;
      rsp_last_in  = rsp_last_ff;
      if (adv) begin
         rsp_valid_in = chain[MAX_BLOCK].vld;
         rsp_plain_in = chain[MAX_BLOCK].acc + 7'(hbt91_pkg::BASE_CHAR);
         rsp_last_in  = chain[MAX_BLOCK].last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_plain_ff <= rsp_plain_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plain_byte = rsp_plain_ff;
   assign rsp_block_last = rsp_last_ff;

   `HBT_ASSERT(a_inj_needs_busy, clock, reset, !inj_ff || busy_ff)
   `HBT_ASSERT_NEXT(a_done_clears_busy, clock, reset, rsp_done, !busy_ff)
   `HBT_ASSERT_NEXT(a_block_start, clock, reset, accept && blk_done, inj_ff && busy_ff && (row_ff == '0))
   `HBT_ASSERT(a_plain_range, clock, reset, !rsp_valid_ff || ((rsp_plain_ff >= 7'(hbt91_pkg::BASE_CHAR)) && (rsp_plain_ff <= 7'(hbt91_pkg::BASE_CHAR + hbt91_pkg::ALPHA - 1))))

endmodule

// ===== verif/hbt91_decrypt_check.sv =====
// ----------------------------------------------------------------------------
// hbt91_decrypt_check
// Watches the character, plaintext and register channels of the mod-91 block
// transform, predicts every plaintext transaction and compares it on arrival.
// ----------------------------------------------------------------------------
module hbt91_decrypt_check #(
   parameter int MAX_BLOCK = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [hbt91_pkg::BYTE_W-1:0]        req_cipher_byte,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [hbt91_pkg::BYTE_W-1:0]        rsp_plain_byte,
   input  logic                                rsp_block_last,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [hbt91_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hbt91_pkg::KEY_W-1:0]         csr_wdata,
   output int                                  fail_count,
   output int                                  open_count,
   output int                                  plain_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BYTE_W    = hbt91_pkg::BYTE_W;
   localparam int SYM_W     = hbt91_pkg::SYM_W;
   localparam int BS_W      = hbt91_pkg::BS_W;
   localparam int KEY_W     = hbt91_pkg::KEY_W;
   localparam int ALPHA     = hbt91_pkg::ALPHA;
   localparam int BASE_CHAR = hbt91_pkg::BASE_CHAR;

   typedef struct {
      logic [BYTE_W-1:0] plain;
      logic              last;
   } plain_char_type;

   plain_char_type    expected_plain[$];
   logic [SYM_W-1:0]  held_symbol[MAX_BLOCK];
   int                held_count = 0;
   logic [BS_W-1:0]   order_reg  = hbt91_pkg::BS_RESET;
   logic [KEY_W-1:0]  key_upper  = hbt91_pkg::KEY_UPPER_RESET;
   logic [KEY_W-1:0]  key_lower  = hbt91_pkg::KEY_LOWER_RESET;
   int                fails      = 0;
   int                checked    = 0;

   always @(posedge clock) begin : watch
      plain_char_type   want;
      int               order;
      int               acc;
      int               entry;
      logic [KEY_W-1:0] word;
      if (reset) begin
         expected_plain.delete();
         held_count = 0;
         order_reg  = hbt91_pkg::BS_RESET;
         key_upper  = hbt91_pkg::KEY_UPPER_RESET;
         key_lower  = hbt91_pkg::KEY_LOWER_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               hbt91_pkg::CSR_BLOCK_SIZE: order_reg = csr_wdata[BS_W-1:0];
               hbt91_pkg::CSR_KEY_UPPER:  key_upper = csr_wdata;
               hbt91_pkg::CSR_KEY_LOWER:  key_lower = csr_wdata;
               default:                   ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (expected_plain.size() == 0) begin
               $error("plain character with no block pending: plain_byte %0d, block_last %0d",
                      rsp_plain_byte, rsp_block_last);
               fails++;
            end else begin
               want = expected_plain.pop_front();
               if (rsp_plain_byte !== want.plain) begin
                  $error("plain_byte mismatch: expected %0d, actual %0d",
                         want.plain, rsp_plain_byte);
                  fails++;
               end
               if (rsp_block_last !== want.last) begin
                  $error("block_last mismatch: expected %0d, actual %0d",
                         want.last, rsp_block_last);
                  fails++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            // A zero order counts as one; anything above the store saturates.
            order = int'(order_reg);
            if (order == 0) begin
               order = 1;
            end
            if (order > MAX_BLOCK) begin
               order = MAX_BLOCK;
            end
            // The symbol is the true residue, so low bytes wrap upwards.
            if (held_count < MAX_BLOCK) begin
               held_symbol[held_count] = SYM_W'((int'(req_cipher_byte) + ALPHA - BASE_CHAR)
                                                % ALPHA);
            end
            held_count++;
            // Once the order is reached the block completes; if the order was
            // lowered mid-block only the first symbols take part.
            if (held_count >= order) begin
               for (int r = 0; r < order; r++) begin
                  word = (r < 2) ? key_upper : key_lower;
                  acc  = 0;
                  for (int c = 0; c < order; c++) begin
                     entry = int'(word[((r % 2) * 4 + c) * SYM_W +: SYM_W]) % ALPHA;
                     acc   = (acc + entry * int'(held_symbol[c])) % ALPHA;
                  end
                  want.plain = BYTE_W'(acc + BASE_CHAR);
                  want.last  = (r == order - 1);
                  expected_plain.insert(expected_plain.size(), want);
               end
               held_count = 0;
            end
         end
      end
      fail_count  <= fails;
      open_count  <= expected_plain.size();
      plain_count <= checked;
   end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives cipher characters and register writes into the mod-91 block
// transform under random gaps and back-pressure, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BYTE_W    = hbt91_pkg::BYTE_W;
   localparam int SYM_W     = hbt91_pkg::SYM_W;
   localparam int BS_W      = hbt91_pkg::BS_W;
   localparam int KEY_W     = hbt91_pkg::KEY_W;
   localparam int CSR_IDX_W = hbt91_pkg::CSR_IDX_W;
   localparam int ALPHA     = hbt91_pkg::ALPHA;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 6;
   localparam int MAX_ORDER    = 4;
   // Minimum number of random cipher characters after the directed opening.
   localparam int STREAM_CHARS = 440;
   // Extra wait once every predicted plaintext transaction has arrived; this
   // comfortably covers a block still in flight through the cell chain.
   localparam int SETTLE_CYCLES = 16;
   // Watchdog limit; it leaves a wide margin over the slowest correct run,
   // allowing for long sender gaps and long receiver stalls together.
   localparam int CYCLE_LIMIT = 500000;
   // Register index beyond the defined list; the block must ignore it.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_cipher_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [BYTE_W-1:0]     rsp_plain_byte;
   logic                  rsp_block_last;
   logic                  csr_valid       = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [KEY_W-1:0]      csr_wdata       = '0;

   int fail_count;
   int open_count;
   int plain_count;
   int chars_sent   = 0;
   int settings_run = 0;
   int cycle_count  = 0;
   int stall_hold   = 0;
   bit gaps_on      = 1'b0;
   bit stalls_on    = 1'b0;

   // The clock runs freely for the whole simulation.
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   hill_block_transform_mod91_top #(
      .MAX_BLOCK (MAX_ORDER)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cipher_byte (req_cipher_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_plain_byte  (rsp_plain_byte),
      .rsp_block_last  (rsp_block_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   hbt91_decrypt_check #(
      .MAX_BLOCK (MAX_ORDER)
   ) decrypt_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cipher_byte (req_cipher_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_plain_byte  (rsp_plain_byte),
      .rsp_block_last  (rsp_block_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .open_count      (open_count),
      .plain_count     (plain_count)
   );

   // Receiver back-pressure. Runs of free cycles alternate with short stalls
   // and, now and then, a long one. When stalls are switched off the channel
   // simply drains, which gives stretches at full rate.
   always @(posedge clock) begin : plain_backpressure
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!stalls_on) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else if (roll < 55) begin
         rsp_stall  <= 1'b0;
         stall_hold <= $urandom_range(0, 6);
      end else if (roll < 92) begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(0, 3);
      end else begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(8, 40);
      end
   end

   // Idle cycles before a character: mostly none, sometimes a few, rarely many.
   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Mostly printable ciphertext, with the odd byte from the full 7-bit range
   // so that the wrap of low and high bytes is exercised.
   function automatic logic [BYTE_W-1:0] random_char();
      if ($urandom_range(0, 99) < 85) begin
         return BYTE_W'($urandom_range(32, 126));
      end
      return BYTE_W'($urandom_range(0, 127));
   endfunction

   // Key word of eight entries; raw entries may exceed 90 and must be reduced.
   function automatic logic [KEY_W-1:0] random_key(input bit raw);
      logic [KEY_W-1:0] word;
      word = '0;
      for (int i = 0; i < 8; i++) begin
         word[i * SYM_W +: SYM_W] = raw ? SYM_W'($urandom_range(0, 127))
                                        : SYM_W'($urandom_range(0, ALPHA - 1));
      end
      return word;
   endfunction

   function automatic logic [KEY_W-1:0] random_word();
      return KEY_W'({$urandom, $urandom});
   endfunction

   // One character transaction. Valid stays high from one character to the
   // next when there is no gap, and the payload is held while stalled.
   task automatic send_char(input logic [BYTE_W-1:0] cipher);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cipher_byte <= cipher;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   // One register write; valid drops afterwards, so the channel rests before the next write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [KEY_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Block size write with random upper bits, which the block must discard.
   task automatic write_order(input int order);
      logic [KEY_W-1:0] data;
      data         = random_word();
      data[BS_W-1:0] = BS_W'(order);
      write_reg(hbt91_pkg::CSR_BLOCK_SIZE, data);
   endtask

   // Waits until every predicted plaintext transaction has arrived and then
   // lets the pipeline empty, so that registers can be written safely.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      settings_run++;
   endtask

   // Watchdog: ends the run if the stimulus or the drain ever hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d plain characters outstanding.",
               cycle_count, open_count);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int order;
      int blocks;
      int stream_start;
      int spare;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: block size one and the identity key, so each plaintext
      // character is simply the symbol plus the space offset. Bytes below the
      // space and above 122 show the wrap of the residue.
      send_char(7'd0);
      send_char(7'd31);
      send_char(7'd32);
      send_char(7'd122);
      send_char(7'd123);
      send_char(7'd127);
      send_char(7'h55);
      settle();

      // Full order with every key entry at its maximum, which reduces to 36.
      gaps_on = 1'b1;
      stalls_on <= 1'b1;
      write_reg(hbt91_pkg::CSR_KEY_UPPER, '1);
      write_reg(hbt91_pkg::CSR_KEY_LOWER, '1);
      write_order(4);
      send_char(7'd126);
      send_char(7'd32);
      send_char(7'd0);
      send_char(7'd127);
      settle();

      // A zero block size behaves as one.
      write_order(0);
      send_char(7'd100);
      settle();

      // An oversized block size saturates to four; the all-zero key gives
      // nothing but spaces.
      write_reg(hbt91_pkg::CSR_KEY_UPPER, '0);
      write_reg(hbt91_pkg::CSR_KEY_LOWER, '0);
      write_order(7);
      send_char(7'd65);
      send_char(7'd90);
      send_char(7'd33);
      send_char(7'd126);
      settle();

      // A write to the spare index must leave the key alone. Then the block
      // size is lowered mid-block: three symbols are held at order four, the
      // order drops to two and the next character completes the block using
      // only the first two symbols.
      write_reg(CSR_SPARE, '1);
      write_reg(hbt91_pkg::CSR_KEY_UPPER, hbt91_pkg::KEY_UPPER_RESET);
      write_reg(hbt91_pkg::CSR_KEY_LOWER, random_key(1'b1));
      write_order(5);
      send_char(7'd40);
      send_char(7'd50);
      send_char(7'd60);
      settle();
      write_order(2);
      send_char(7'd70);
      settle();

      // Raising the order mid-block simply extends the block.
      write_reg(hbt91_pkg::CSR_KEY_UPPER, random_key(1'b1));
      write_order(3);
      send_char(7'd45);
      send_char(7'd112);
      settle();
      write_order(4);
      send_char(7'd77);
      send_char(7'd3);
      settle();

      // Random stream: each setting gets a fresh block size and usually new
      // keys, then whole blocks of random characters. Some settings end on a
      // partial block, which the next setting may complete at another order.
      stream_start = chars_sent;
      while (chars_sent - stream_start < STREAM_CHARS) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         stalls_on <= ($urandom_range(0, 3) != 0);
         spare = $urandom_range(0, 9);
         if (spare == 0) begin
            order = 0;
         end else if (spare == 1) begin
            order = $urandom_range(5, 7);
         end else begin
            order = $urandom_range(1, 4);
         end
         if ($urandom_range(0, 2) != 0) begin
            write_reg(hbt91_pkg::CSR_KEY_UPPER, random_key($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 2) != 0) begin
            write_reg(hbt91_pkg::CSR_KEY_LOWER, random_key($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 7) == 0) begin
            write_reg(CSR_SPARE, random_word());
         end
         write_order(order);
         if (order == 0) begin
            order = 1;
         end else if (order > MAX_ORDER) begin
            order = MAX_ORDER;
         end
         blocks = $urandom_range(1, 10);
         repeat (blocks * order) send_char(random_char());
         if (order > 1 && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, order - 1)) send_char(random_char());
         end
         settle();
      end

      $display("Sent %0d cipher characters over %0d register settings;",
               chars_sent, settings_run);
      $display("%0d plain characters checked.", plain_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== hill_block_transform_mod91_top.f =====
+incdir+hw/rtl
hw/rtl/hbt91_pkg.sv
hw/rtl/hbt91_cell.sv
hw/rtl/hill_block_transform_mod91_top.sv
verif/hbt91_decrypt_check.sv
verif/testbench.sv
